// File: src/dmwsc_pkg.sv
package dmwsc_pkg;

    // Geometry of the cache
    localparam int LINES       = 256;
    localparam int WORD_BITS   = 32;
    localparam int SECTOR_BITS = 48;
    localparam int INDEX_BITS  = $clog2(LINES);
    localparam int TAG_BITS    = SECTOR_BITS - INDEX_BITS;
    // Line store entry: dirty bit, tag, word
    localparam int LINE_BITS   = 1 + TAG_BITS + WORD_BITS;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FILL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_READ_DATA  = 2'd0,
        KIND_WRITE_ACK  = 2'd1,
        KIND_WRITE_BACK = 2'd2,
        KIND_FETCH      = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SEND
    } state_t;

    // One result beat
    typedef struct packed {
        kind_t                  kind;
        logic [SECTOR_BITS-1:0] sector;
        logic [WORD_BITS-1:0]   word;
        logic                   done;
        logic                   last;
    } res_t;

endpackage

// File: src/dmwsc_ram.sv
module dmwsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/direct_mapped_writeback_sector_cache.sv
// Direct-mapped write-back sector cache. A sector maps to line sector mod LINES with the
// upper bits as tag; dirty bit, tag and word sit in a single-port-read, single-port-write
// RAM with a registered read, while valid bits are flip-flops cleared at reset and read
// into a register alongside the RAM, so the cache is usable straight out of reset. Items
// are handled one at a time: the accept cycle starts the RAM read, the lookup cycle
// compares the tag and writes the line back, and each result is then loaded into the
// output register in the send state, a victim write back ahead of the main result; a
// stall on the result side holds the send state, and an unused operation code gives no
// result and skips the send state.
// Since the line is written before the next item is read, accesses never overlap.
module direct_mapped_writeback_sector_cache (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [dmwsc_pkg::SECTOR_BITS-1:0]  sector,
    input  logic [dmwsc_pkg::WORD_BITS-1:0]    write_word,
    input  logic                               end_of_request,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         kind,
    output logic [dmwsc_pkg::SECTOR_BITS-1:0]  out_sector,
    output logic [dmwsc_pkg::WORD_BITS-1:0]    out_word,
    output logic                               request_done,
    output logic                               last
);

    import dmwsc_pkg::*;

    state_t                 state_reg, state_next;
    op_t                    op_reg;
    logic [SECTOR_BITS-1:0] sec_reg;
    logic [WORD_BITS-1:0]   word_reg;
    logic                   eor_reg;
    logic [LINES-1:0]       valid_reg;
    logic                   rd_valid_reg;
    res_t                   pend0_reg, pend0_next;
    res_t                   pend1_reg, pend1_next;
    logic                   pend_two_reg, pend_two_next;
    logic                   has_res;
    res_t                   out_res_reg;
    logic                   out_valid_reg;

    logic                   accept;
    logic                   slot_free;
    logic                   load_out;
    logic                   in_stall_c;

    logic [INDEX_BITS-1:0]  lk_idx;
    logic [TAG_BITS-1:0]    lk_tag;
    logic [LINE_BITS-1:0]   rd_line;
    logic                   rd_dirty;
    logic [TAG_BITS-1:0]    rd_tag;
    logic [WORD_BITS-1:0]   rd_word;
    logic                   line_hit;
    logic                   line_dirty;
    logic                   evict;
    logic [SECTOR_BITS-1:0] victim_sec;
    res_t                   wb_res;
    logic                   ram_we;
    logic                   line_we;
    logic                   bits_we;
    logic                   new_valid;
    logic                   new_dirty;
    logic [TAG_BITS-1:0]    new_tag;
    logic [WORD_BITS-1:0]   new_word;

    assign accept    = in_valid && !in_stall_c;
    assign slot_free = !out_valid_reg || !out_stall;
    assign line_we   = ram_we && (state_reg == ST_LOOKUP);

    // Line store: dirty bit above tag above word
    dmwsc_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (LINES)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (lk_idx),
        .wdata ({new_dirty, new_tag, new_word}),
        .re    (accept),
        .raddr (sector[INDEX_BITS-1:0]),
        .rdata (rd_line)
    );

    // Split the held item and the line read back
    assign lk_idx     = sec_reg[INDEX_BITS-1:0];
    assign lk_tag     = sec_reg[SECTOR_BITS-1:INDEX_BITS];
    assign rd_dirty   = rd_line[LINE_BITS-1];
    assign rd_tag     = rd_line[LINE_BITS-2:WORD_BITS];
    assign rd_word    = rd_line[WORD_BITS-1:0];
    assign line_hit   = rd_valid_reg && (rd_tag == lk_tag);
    assign line_dirty = rd_valid_reg && rd_dirty;
    assign evict      = line_dirty && (rd_tag != lk_tag);
    assign victim_sec = {rd_tag, lk_idx};

    always_comb
    begin
        wb_res.kind   = KIND_WRITE_BACK;
        wb_res.sector = victim_sec;
        wb_res.word   = rd_word;
        wb_res.done   = 1'b0;
        wb_res.last   = 1'b0;
    end

    // Decide results and line update for the item under lookup
    always_comb
    begin
        res_t r_main;
        r_main.kind   = KIND_READ_DATA;
        r_main.sector = sec_reg;
        r_main.word   = '0;
        r_main.done   = eor_reg;
        r_main.last   = 1'b1;
        has_res       = 1'b1;
        ram_we        = 1'b0;
        bits_we       = 1'b0;
        new_valid     = rd_valid_reg;
        new_dirty     = line_dirty;
        new_tag       = rd_tag;
        new_word      = rd_word;
        case (op_reg)
            OP_READ:
            begin
                if (line_hit)
                begin
                    r_main.word = rd_word;
                end
                else
                begin
                    r_main.kind = KIND_FETCH;
                    r_main.done = 1'b0;
                    // keep the victim valid, drop only its dirty mark
                    if (evict)
                    begin
                        ram_we    = 1'b1;
                        new_dirty = 1'b0;
                    end
                end
            end
            OP_WRITE:
            begin
                r_main.kind = KIND_WRITE_ACK;
                ram_we      = 1'b1;
                bits_we     = 1'b1;
                new_valid   = 1'b1;
                new_dirty   = 1'b1;
                new_tag     = lk_tag;
                new_word    = word_reg;
            end
            OP_FILL:
            begin
                if (line_hit && line_dirty)
                begin
                    r_main.word = rd_word;
                end
                else
                begin
                    r_main.word = word_reg;
                    ram_we      = 1'b1;
                    bits_we     = 1'b1;
                    new_valid   = 1'b1;
                    new_dirty   = 1'b0;
                    new_tag     = lk_tag;
                    new_word    = word_reg;
                end
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase

        // Queue the victim write back ahead of the main result
        pend0_next    = pend0_reg;
        pend1_next    = pend1_reg;
        pend_two_next = pend_two_reg;
        if (state_reg == ST_LOOKUP)
        begin
            if (evict && !(op_reg == OP_READ && line_hit)
                && !(op_reg == OP_FILL && line_hit && line_dirty) && has_res)
            begin
                pend0_next    = wb_res;
                pend1_next    = r_main;
                pend_two_next = 1'b1;
            end
            else
            begin
                pend0_next    = r_main;
                pend_two_next = 1'b0;
            end
        end
        else if (load_out && pend_two_reg)
        begin
            pend0_next    = pend1_reg;
            pend_two_next = 1'b0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = has_res ? ST_SEND : ST_IDLE;
            end
            ST_SEND:
            begin
                if (slot_free && !pend_two_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall_c = 1'b1;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall_c = 1'b0;
            end
            ST_SEND:
            begin
                load_out = slot_free;
            end
            default:
            begin
                in_stall_c = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            pend_two_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_two_reg <= pend_two_next;
            if (state_reg == ST_LOOKUP && bits_we)
            begin
                valid_reg[lk_idx] <= new_valid;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold the item, its valid bit, pending results and output beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op_t'(operation);
            sec_reg      <= sector;
            word_reg     <= write_word;
            eor_reg      <= end_of_request;
            rd_valid_reg <= valid_reg[sector[INDEX_BITS-1:0]];
        end
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
        if (load_out)
        begin
            out_res_reg <= pend0_reg;
        end
    end

    assign in_stall     = in_stall_c;
    assign out_valid    = out_valid_reg;
    assign kind         = out_res_reg.kind;
    assign out_sector   = out_res_reg.sector;
    assign out_word     = out_res_reg.word;
    assign request_done = out_res_reg.done;
    assign last         = out_res_reg.last;

    // A victim write back never names the sector under lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && evict) |-> victim_sec != sec_reg)
        else $error("victim names the looked-up sector");

    // An accepted beat is always looked up in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> state_reg == ST_LOOKUP)
        else $error("accepted beat not looked up");

    // The line store is never written in a cycle that accepts a beat
    assert property (@(posedge clk) disable iff (!rst_n) line_we |-> !accept)
        else $error("line store written outside lookup");

    // A beat loaded with a pending second result stays in the send state
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && pend_two_reg) |=> state_reg == ST_SEND && !pend_two_reg)
        else $error("second result lost");

    // Every result after lookup ends with a last-flagged beat before a new accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !pend_two_reg) |-> pend0_reg.last)
        else $error("final beat not flagged last");

endmodule
